/* rtl/ata_tf_pkg.sv */
// Shared types and constants for the ATA task file / CHS sequencer.
// No dependencies; used by ata_tf_ctrl, ata_tf_dp and the top level.
package ata_tf_pkg;

  localparam int UNITS = 2;

  // ATA opcodes
  localparam logic [7:0] OP_RECAL_HI  = 8'h10;
  localparam logic [7:0] OP_HI_MASK   = 8'hF0;
  localparam logic [7:0] OP_LO_MASK   = 8'h0F;
  localparam logic [7:0] OP_IDENTIFY  = 8'hEC;
  localparam logic [7:0] OP_INIT_PARM = 8'h91;
  localparam logic [7:0] OP_SET_MULT  = 8'hC6;
  localparam logic [7:0] OP_READ      = 8'h20;
  localparam logic [7:0] OP_READ_MULT = 8'hC4;
  localparam logic [7:0] OP_WRITE     = 8'h30;
  localparam logic [7:0] OP_WRITE_MULT = 8'hC5;

  localparam logic [7:0] ERR_ABORT = 8'h04;
  localparam logic [8:0] FULL_COUNT = 9'h100;

  // Status bits
  localparam logic [4:0] ST_RDY = 5'h01;
  localparam logic [4:0] ST_REQ = 5'h02;
  localparam logic [4:0] ST_IRQ = 5'h04;
  localparam logic [4:0] ST_END = 5'h08;
  localparam logic [4:0] ST_ERR = 5'h10;

  // Transfer kinds
  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_WRITE = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] CFG_HEADS0 = 3'd0;
  localparam logic [2:0] CFG_SPT0   = 3'd1;
  localparam logic [2:0] CFG_OFS0   = 3'd2;
  localparam logic [2:0] CFG_HEADS1 = 3'd3;
  localparam logic [2:0] CFG_SPT1   = 3'd4;
  localparam logic [2:0] CFG_OFS1   = 3'd5;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_RD   = 3'd1,
    MODE_RDM  = 3'd2,
    MODE_WR   = 3'd3,
    MODE_WRM  = 3'd4
  } mode_e;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_EXEC = 6'b000010,
    S_MUL2 = 6'b000100,
    S_LBA  = 6'b001000,
    S_STEP = 6'b010000,
    S_DONE = 6'b100000
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic latch;
    logic exec;
    logic mul2;
    logic lba;
    logic step;
    logic load_out;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_cmd;
    logic is_data;
    logic buf_ok;
    logic last_step;
  } dp_sts_t;

endpackage

/* rtl/ata_tf_ctrl.sv */
// Sequencing state machine for the ATA task file / CHS sequencer.
// Depends on ata_tf_pkg; drives ata_tf_dp through dp_cmd_t.
module ata_tf_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  ata_tf_pkg::dp_sts_t sts_i,
  output ata_tf_pkg::dp_cmd_t cmd_o
);

  ata_tf_pkg::state_e state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic load;

  assign in_ready_o  = (state_q == ata_tf_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;
  assign load = (state_q == ata_tf_pkg::S_DONE) && (!out_valid_q || out_ready_i);

  // Next state and datapath strobes
  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    case (state_q)
      ata_tf_pkg::S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d = ata_tf_pkg::S_EXEC;
        end
      end
      ata_tf_pkg::S_EXEC: begin
        cmd_o.exec = 1'b1;
        if (sts_i.is_cmd) begin
          state_d = sts_i.is_data ? ata_tf_pkg::S_MUL2 : ata_tf_pkg::S_DONE;
        end else begin
          state_d = sts_i.buf_ok ? ata_tf_pkg::S_STEP : ata_tf_pkg::S_IDLE;
        end
      end
      ata_tf_pkg::S_MUL2: begin
        cmd_o.mul2 = 1'b1;
        state_d = ata_tf_pkg::S_LBA;
      end
      ata_tf_pkg::S_LBA: begin
        cmd_o.lba = 1'b1;
        state_d = ata_tf_pkg::S_DONE;
      end
      ata_tf_pkg::S_STEP: begin
        cmd_o.step = 1'b1;
        if (sts_i.last_step) state_d = ata_tf_pkg::S_DONE;
      end
      ata_tf_pkg::S_DONE: begin
        if (load) begin
          cmd_o.load_out = 1'b1;
          state_d = ata_tf_pkg::S_IDLE;
        end
      end
      default: state_d = ata_tf_pkg::S_IDLE;
    endcase
  end

  // Result beat valid
  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if (load) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ata_tf_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

/* rtl/ata_tf_dp.sv */
// Datapath of the ATA task file / CHS sequencer: config, CHS state, LBA math.
// Depends on ata_tf_pkg; strobed by ata_tf_ctrl.
module ata_tf_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ata_tf_pkg::dp_cmd_t cmd_i,
  output ata_tf_pkg::dp_sts_t sts_o,
  input  logic                cfg_valid_i,
  input  logic [2:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i,
  input  logic                command_i,
  input  logic [7:0]          ata_opcode_i,
  input  logic [7:0]          count_in_i,
  input  logic [7:0]          sector_in_i,
  input  logic [15:0]         cylinder_in_i,
  input  logic [7:0]          drive_head_in_i,
  output logic                taskfile_valid_o,
  output logic [7:0]          error_code_o,
  output logic [7:0]          count_out_o,
  output logic [7:0]          sector_out_o,
  output logic [15:0]         cylinder_out_o,
  output logic [7:0]          drive_head_out_o,
  output logic [4:0]          status_bits_o,
  output logic [1:0]          transfer_kind_o,
  output logic [31:0]         transfer_lba_o,
  output logic [7:0]          transfer_sectors_o
);

  // Configuration and block size
  logic [4:0]  heads_q  [ata_tf_pkg::UNITS];
  logic [7:0]  spt_q    [ata_tf_pkg::UNITS];
  logic [31:0] ofs_q    [ata_tf_pkg::UNITS];
  logic [7:0]  bsize_q  [ata_tf_pkg::UNITS];

  // Latched input item
  logic        l_buf_q;
  logic [7:0]  l_op_q, l_cnt_q, l_sec_q, l_dh_q;
  logic [15:0] l_cyl_q;

  // Transfer state
  ata_tf_pkg::mode_e mode_q;
  logic [8:0]  rem_q;
  logic [7:0]  sec_q;
  logic [3:0]  head_q;
  logic [15:0] cyl_q;
  logic        unit_q;
  logic [3:0]  dh_up_q;
  logic [7:0]  lcount_q;
  logic [31:0] lba_q;

  // Working registers
  logic [20:0] prod1_q;
  logic [28:0] prod2_q;
  logic [7:0]  n_q, left_q;
  logic [31:0] lba0_q;
  logic [1:0]  kind_q;

  // Decode of the latched item
  logic l_unit, op_recal, op_echo, op_setm, op_data, op_rd, op_rdm, op_wr;
  logic [7:0] bs_eff;
  logic [8:0] n_full;
  logic [4:0] h_inc;

  always_comb begin
    l_unit   = (ata_tf_pkg::UNITS > 1) ? l_dh_q[4] : 1'b0;
    op_recal = (l_op_q & ata_tf_pkg::OP_HI_MASK) == ata_tf_pkg::OP_RECAL_HI;
    op_echo  = (l_op_q == ata_tf_pkg::OP_IDENTIFY) || (l_op_q == ata_tf_pkg::OP_INIT_PARM);
    op_setm  = (l_op_q == ata_tf_pkg::OP_SET_MULT);
    op_rd    = (l_op_q == ata_tf_pkg::OP_READ);
    op_rdm   = (l_op_q == ata_tf_pkg::OP_READ_MULT);
    op_wr    = (l_op_q == ata_tf_pkg::OP_WRITE);
    op_data  = op_rd || op_rdm || op_wr || (l_op_q == ata_tf_pkg::OP_WRITE_MULT);
    bs_eff   = (bsize_q[unit_q] == 8'd0) ? 8'd1 : bsize_q[unit_q];
    if ((mode_q == ata_tf_pkg::MODE_RDM) || (mode_q == ata_tf_pkg::MODE_WRM)) begin
      n_full = (rem_q < {1'b0, bs_eff}) ? rem_q : {1'b0, bs_eff};
    end else begin
      n_full = 9'd1;
    end
    h_inc = {1'b0, head_q} + 5'd1;
  end

  assign sts_o.is_cmd    = !l_buf_q;
  assign sts_o.is_data   = !op_recal && !op_echo && !op_setm && op_data;
  assign sts_o.buf_ok    = (mode_q != ata_tf_pkg::MODE_IDLE) && (rem_q != 9'd0);
  assign sts_o.last_step = (left_q == 8'd1);

  // Configuration writes and block size
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int u = 0; u < ata_tf_pkg::UNITS; u++) begin
        heads_q[u] <= 5'd16;
        spt_q[u]   <= 8'd63;
        ofs_q[u]   <= 32'd0;
        bsize_q[u] <= 8'd0;
      end
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          ata_tf_pkg::CFG_HEADS0: heads_q[0] <= cfg_data_i[4:0];
          ata_tf_pkg::CFG_SPT0:   spt_q[0]   <= cfg_data_i[7:0];
          ata_tf_pkg::CFG_OFS0:   ofs_q[0]   <= cfg_data_i;
          ata_tf_pkg::CFG_HEADS1: heads_q[1] <= cfg_data_i[4:0];
          ata_tf_pkg::CFG_SPT1:   spt_q[1]   <= cfg_data_i[7:0];
          ata_tf_pkg::CFG_OFS1:   ofs_q[1]   <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.exec && !l_buf_q && !op_recal && !op_echo && op_setm) begin
        bsize_q[l_unit] <= l_cnt_q;
      end
    end
  end

  // Input item latch
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      l_buf_q <= command_i;
      l_op_q  <= ata_opcode_i;
      l_cnt_q <= count_in_i;
      l_sec_q <= sector_in_i;
      l_cyl_q <= cylinder_in_i;
      l_dh_q  <= drive_head_in_i;
    end
  end

  // Transfer state machine data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= ata_tf_pkg::MODE_IDLE;
      rem_q    <= '0;
      sec_q    <= '0;
      head_q   <= '0;
      cyl_q    <= '0;
      unit_q   <= 1'b0;
      dh_up_q  <= '0;
      lcount_q <= '0;
      lba_q    <= '0;
    end else begin
      if (cmd_i.exec) begin
        if (!l_buf_q) begin
          mode_q <= ata_tf_pkg::MODE_IDLE;
          if (sts_o.is_data) begin
            unit_q   <= l_unit;
            sec_q    <= l_sec_q;
            cyl_q    <= l_cyl_q;
            head_q   <= l_dh_q[3:0];
            dh_up_q  <= l_dh_q[7:4];
            lcount_q <= l_cnt_q;
            rem_q    <= (l_cnt_q == 8'd0) ? ata_tf_pkg::FULL_COUNT : {1'b0, l_cnt_q};
          end
        end else if (!sts_o.buf_ok) begin
          mode_q <= ata_tf_pkg::MODE_IDLE;
        end
      end
      // LBA and mode of a new data command
      if (cmd_i.lba) begin
        lba_q <= 32'(prod2_q) + 32'(l_sec_q) - 32'd1 + ofs_q[unit_q];
        if (op_rd)       mode_q <= ata_tf_pkg::MODE_RD;
        else if (op_rdm) mode_q <= ata_tf_pkg::MODE_RDM;
        else if (op_wr)  mode_q <= ata_tf_pkg::MODE_WR;
        else             mode_q <= ata_tf_pkg::MODE_WRM;
      end
      // One sector: CHS advance unless it is the last one
      if (cmd_i.step) begin
        if (rem_q != 9'd1) begin
          if (sec_q == spt_q[unit_q]) begin
            sec_q <= 8'd1;
            if (h_inc == heads_q[unit_q]) begin
              head_q <= 4'd0;
              cyl_q  <= cyl_q + 16'd1;
            end else begin
              head_q <= h_inc[3:0];
            end
          end else begin
            sec_q <= sec_q + 8'd1;
          end
        end
        rem_q <= rem_q - 9'd1;
        if (left_q == 8'd1) begin
          lba_q <= lba0_q + 32'(n_q);
          if (rem_q == 9'd1) mode_q <= ata_tf_pkg::MODE_IDLE;
        end
      end
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      prod1_q <= 21'(l_cyl_q) * 21'(heads_q[l_unit]);
      n_q     <= n_full[7:0];
      left_q  <= n_full[7:0];
      lba0_q  <= lba_q;
      kind_q  <= ((mode_q == ata_tf_pkg::MODE_RD) || (mode_q == ata_tf_pkg::MODE_RDM)) ?
                 ata_tf_pkg::KIND_READ : ata_tf_pkg::KIND_WRITE;
    end
    if (cmd_i.mul2) begin
      prod2_q <= 29'(prod1_q + 21'(head_q)) * 29'(spt_q[unit_q]);
    end
    if (cmd_i.step) left_q <= left_q - 8'd1;
  end

  // Result beat register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      taskfile_valid_o   <= 1'b0;
      error_code_o       <= 8'd0;
      count_out_o        <= 8'd0;
      sector_out_o       <= 8'd0;
      cylinder_out_o     <= 16'd0;
      drive_head_out_o   <= 8'd0;
      status_bits_o      <= ata_tf_pkg::ST_END | ata_tf_pkg::ST_IRQ;
      transfer_kind_o    <= ata_tf_pkg::KIND_NONE;
      transfer_lba_o     <= 32'd0;
      transfer_sectors_o <= 8'd0;
      if (l_buf_q) begin
        taskfile_valid_o   <= 1'b1;
        count_out_o        <= lcount_q;
        sector_out_o       <= sec_q;
        cylinder_out_o     <= cyl_q;
        drive_head_out_o   <= {dh_up_q, head_q};
        status_bits_o      <= ((kind_q == ata_tf_pkg::KIND_WRITE) && (rem_q == 9'd0)) ?
                              (ata_tf_pkg::ST_END | ata_tf_pkg::ST_IRQ) : ata_tf_pkg::ST_IRQ;
        transfer_kind_o    <= kind_q;
        transfer_lba_o     <= lba0_q;
        transfer_sectors_o <= n_q;
      end else if (op_recal) begin
        taskfile_valid_o <= 1'b1;
        sector_out_o     <= 8'd1;
        drive_head_out_o <= l_dh_q & ata_tf_pkg::OP_HI_MASK;
      end else if (op_echo) begin
        taskfile_valid_o <= 1'b1;
        count_out_o      <= l_cnt_q;
        sector_out_o     <= l_sec_q;
        cylinder_out_o   <= l_cyl_q;
        drive_head_out_o <= l_dh_q;
      end else if (op_setm) begin
        status_bits_o <= ata_tf_pkg::ST_END | ata_tf_pkg::ST_IRQ;
      end else if (op_data) begin
        status_bits_o <= (op_rd || op_rdm) ? ata_tf_pkg::ST_RDY : ata_tf_pkg::ST_REQ;
      end else begin
        // unknown opcode: aborted
        taskfile_valid_o <= 1'b1;
        error_code_o     <= ata_tf_pkg::ERR_ABORT;
        count_out_o      <= l_cnt_q;
        sector_out_o     <= l_sec_q;
        cylinder_out_o   <= l_cyl_q;
        drive_head_out_o <= l_dh_q & (ata_tf_pkg::OP_HI_MASK | ata_tf_pkg::OP_LO_MASK);
        status_bits_o    <= ata_tf_pkg::ST_END | ata_tf_pkg::ST_IRQ | ata_tf_pkg::ST_ERR;
      end
    end
  end

endmodule

/* rtl/ata_taskfile_chs_sequencer.sv */
// Top level of the two-unit ATA task file / CHS sequencer.
// Depends on ata_tf_pkg, ata_tf_ctrl and ata_tf_dp.
//
// One item at a time. A command beat passes EXEC and DONE; a read/write one
// also passes MUL2 and LBA, as its start LBA goes through two registered
// multiplies. A buffer-ready beat with no transfer running gives no result;
// any other passes EXEC, a STEP per sector moved (1, or up to the block size in
// multiple modes) and DONE, as the CHS address advances one sector per cycle.
// The result sits in an output register, so the next item may be taken while it
// waits. Configuration writes are always ready and must be done while idle.
module ata_taskfile_chs_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        command_i,
  input  logic [7:0]  ata_opcode_i,
  input  logic [7:0]  count_in_i,
  input  logic [7:0]  sector_in_i,
  input  logic [15:0] cylinder_in_i,
  input  logic [7:0]  drive_head_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        taskfile_valid_o,
  output logic [7:0]  error_code_o,
  output logic [7:0]  count_out_o,
  output logic [7:0]  sector_out_o,
  output logic [15:0] cylinder_out_o,
  output logic [7:0]  drive_head_out_o,
  output logic [4:0]  status_bits_o,
  output logic [1:0]  transfer_kind_o,
  output logic [31:0] transfer_lba_o,
  output logic [7:0]  transfer_sectors_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  ata_tf_pkg::dp_cmd_t cmd;
  ata_tf_pkg::dp_sts_t sts;

  assign cfg_ready_o = 1'b1;

  ata_tf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ata_tf_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .command_i          (command_i),
    .ata_opcode_i       (ata_opcode_i),
    .count_in_i         (count_in_i),
    .sector_in_i        (sector_in_i),
    .cylinder_in_i      (cylinder_in_i),
    .drive_head_in_i    (drive_head_in_i),
    .taskfile_valid_o   (taskfile_valid_o),
    .error_code_o       (error_code_o),
    .count_out_o        (count_out_o),
    .sector_out_o       (sector_out_o),
    .cylinder_out_o     (cylinder_out_o),
    .drive_head_out_o   (drive_head_out_o),
    .status_bits_o      (status_bits_o),
    .transfer_kind_o    (transfer_kind_o),
    .transfer_lba_o     (transfer_lba_o),
    .transfer_sectors_o (transfer_sectors_o)
  );

  // The input is never ready in the cycle after a beat is accepted
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken twice in a row");

  // A transfer result always writes back the task file
  a_xfer_has_tf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (transfer_kind_o != ata_tf_pkg::KIND_NONE) |-> taskfile_valid_o)
    else $error("transfer without task file");

  // A transfer result moves at least one sector; none otherwise
  a_xfer_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((transfer_kind_o == ata_tf_pkg::KIND_NONE) ==
                     (transfer_sectors_o == 8'd0)))
    else $error("sector count does not match transfer kind");

endmodule

/* test/ata_taskfile_chs_sequencer_tb.sv */
// Self-checking testbench for ata_taskfile_chs_sequencer: directed table, then random
// command/buffer sequences under several geometries and idling mixes.
// Depends on ata_tf_pkg and the ata_taskfile_chs_sequencer RTL.
module ata_taskfile_chs_sequencer_tb;
  import ata_tf_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int SETTLE      = 300;

  typedef struct packed {
    logic        cmd;
    logic [7:0]  op;
    logic [7:0]  cnt;
    logic [7:0]  sec;
    logic [15:0] cyl;
    logic [7:0]  dh;
  } ata_item_t;

  typedef struct packed {
    logic        tfv;
    logic [7:0]  err;
    logic [7:0]  cnt;
    logic [7:0]  sec;
    logic [15:0] cyl;
    logic [7:0]  dh;
    logic [4:0]  st;
    logic [1:0]  kind;
    logic [31:0] lba;
    logic [7:0]  n;
  } tf_result_t;

  typedef struct packed {
    ata_item_t  item;
    logic       typed;
    tf_result_t res;
  } tf_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        command_i = 1'b0;
  logic [7:0]  ata_opcode_i = '0;
  logic [7:0]  count_in_i = '0;
  logic [7:0]  sector_in_i = '0;
  logic [15:0] cylinder_in_i = '0;
  logic [7:0]  drive_head_in_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        taskfile_valid_o;
  logic [7:0]  error_code_o;
  logic [7:0]  count_out_o;
  logic [7:0]  sector_out_o;
  logic [15:0] cylinder_out_o;
  logic [7:0]  drive_head_out_o;
  logic [4:0]  status_bits_o;
  logic [1:0]  transfer_kind_o;
  logic [31:0] transfer_lba_o;
  logic [7:0]  transfer_sectors_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  ata_taskfile_chs_sequencer DUT (.*);

  always #2 clk_i = ~clk_i;

  // Predictor state
  mode_e       drv_mode = MODE_IDLE;
  logic [8:0]  sectors_left = '0;
  logic [7:0]  chs_sector = '0;
  logic [3:0]  chs_head = '0;
  logic [15:0] chs_cyl = '0;
  logic        chs_unit = 1'b0;
  logic [3:0]  dh_upper = '0;
  logic [7:0]  cmd_count = '0;
  logic [31:0] next_lba = '0;
  logic [7:0]  block_sz [2] = '{8'd0, 8'd0};
  logic [4:0]  geo_heads [2] = '{5'd16, 5'd16};
  logic [7:0]  geo_spt [2] = '{8'd63, 8'd63};
  logic [31:0] geo_ofs [2] = '{32'd0, 32'd0};

  tf_result_t  expected_q [$];
  int          errors = 0;
  int          cycles = 0;
  int          snd_idle = 0;
  int          rcv_stall = 0;
  int          results_sent = 0;
  logic        hold_req = 1'b0;
  logic        hold_taken = 1'b0;
  int          hold_left = 0;

  function automatic tf_result_t tf_pack(logic tfv, logic [7:0] err, logic [7:0] cnt,
      logic [7:0] sec, logic [15:0] cyl, logic [7:0] dh, logic [4:0] st,
      logic [1:0] kind, logic [31:0] lba, logic [7:0] n);
    tf_result_t r;
    r = '{tfv, err, cnt, sec, cyl, dh, st, kind, lba, n};
    return r;
  endfunction

  // One sector step of the CHS address; the last sector of a command stays put
  function automatic void chs_advance();
    logic [4:0] h;
    if (sectors_left == 9'd1) return;
    if (chs_sector == geo_spt[chs_unit]) begin
      h = {1'b0, chs_head} + 5'd1;
      chs_sector = 8'd1;
      if (h == geo_heads[chs_unit]) begin
        chs_head = 4'd0;
        chs_cyl = chs_cyl + 16'd1;
      end else begin
        chs_head = h[3:0];
      end
    end else begin
      chs_sector = chs_sector + 8'd1;
    end
  endfunction

  // Computes the task file write-back for one accepted beat
  function automatic bit predict_taskfile(input ata_item_t it, output tf_result_t r);
    logic        u;
    logic [31:0] chs;
    logic [31:0] lba;
    logic [8:0]  n;
    logic [8:0]  bs;
    logic [1:0]  kind;
    logic [4:0]  st;
    r = '0;
    u = it.dh[4];
    if (!it.cmd) begin
      drv_mode = MODE_IDLE;
      if ((it.op & OP_HI_MASK) == OP_RECAL_HI) begin
        r = tf_pack(1, 0, 0, 1, 0, it.dh & OP_HI_MASK, ST_END | ST_IRQ, KIND_NONE, 0, 0);
      end else if (it.op == OP_IDENTIFY || it.op == OP_INIT_PARM) begin
        r = tf_pack(1, 0, it.cnt, it.sec, it.cyl, it.dh, ST_END | ST_IRQ, KIND_NONE, 0, 0);
      end else if (it.op == OP_SET_MULT) begin
        block_sz[u] = it.cnt;
        r = tf_pack(0, 0, 0, 0, 0, 0, ST_END | ST_IRQ, KIND_NONE, 0, 0);
      end else if (it.op == OP_READ || it.op == OP_READ_MULT ||
                   it.op == OP_WRITE || it.op == OP_WRITE_MULT) begin
        chs_unit = u;
        chs_sector = it.sec;
        chs_cyl = it.cyl;
        chs_head = it.dh[3:0];
        dh_upper = it.dh[7:4];
        cmd_count = it.cnt;
        sectors_left = (it.cnt == 8'd0) ? FULL_COUNT : {1'b0, it.cnt};
        chs = (32'(it.cyl) * 32'(geo_heads[u]) + 32'(chs_head)) * 32'(geo_spt[u])
              + 32'(it.sec) - 32'd1;
        next_lba = chs + geo_ofs[u];
        case (it.op)
          OP_READ:      begin drv_mode = MODE_RD;  st = ST_RDY; end
          OP_READ_MULT: begin drv_mode = MODE_RDM; st = ST_RDY; end
          OP_WRITE:     begin drv_mode = MODE_WR;  st = ST_REQ; end
          default:      begin drv_mode = MODE_WRM; st = ST_REQ; end
        endcase
        r = tf_pack(0, 0, 0, 0, 0, 0, st, KIND_NONE, 0, 0);
      end else begin
        r = tf_pack(1, ERR_ABORT, it.cnt, it.sec, it.cyl, it.dh, ST_END | ST_IRQ | ST_ERR,
                    KIND_NONE, 0, 0);
      end
      return 1;
    end
    // Buffer-ready beat
    if (drv_mode == MODE_IDLE || sectors_left == 9'd0) begin
      drv_mode = MODE_IDLE;
      return 0;
    end
    n = 9'd1;
    if (drv_mode == MODE_RDM || drv_mode == MODE_WRM) begin
      bs = (block_sz[chs_unit] == 8'd0) ? 9'd1 : {1'b0, block_sz[chs_unit]};
      n = (sectors_left < bs) ? sectors_left : bs;
    end
    kind = (drv_mode == MODE_RD || drv_mode == MODE_RDM) ? KIND_READ : KIND_WRITE;
    lba = next_lba;
    for (int k = 0; k < n; k++) begin
      chs_advance();
      sectors_left = sectors_left - 9'd1;
    end
    next_lba = lba + 32'(n);
    st = (kind == KIND_WRITE && sectors_left == 9'd0) ? (ST_END | ST_IRQ) : ST_IRQ;
    if (sectors_left == 9'd0) drv_mode = MODE_IDLE;
    r = tf_pack(1, 0, cmd_count, chs_sector, chs_cyl, {dh_upper, chs_head}, st, kind,
                lba, n[7:0]);
    return 1;
  endfunction

  // Offers one beat, idling first at the phase's rate; valid stays up until taken
  task automatic send_beat(input ata_item_t it, input logic typed, input tf_result_t typed_res);
    tf_result_t r;
    bit         has;
    while ($urandom_range(99) < snd_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    command_i       <= it.cmd;
    ata_opcode_i    <= it.op;
    count_in_i      <= it.cnt;
    sector_in_i     <= it.sec;
    cylinder_in_i   <= it.cyl;
    drive_head_in_i <= it.dh;
    do @(posedge clk_i); while (!in_ready_o);
    has = predict_taskfile(it, r);
    if (has) begin
      expected_q.push_back(typed ? typed_res : r);
      results_sent++;
    end
  endtask

  task automatic send_item(input ata_item_t it);
    send_beat(it, 1'b0, '0);
  endtask

  // Waits until every expected result is back, then lets a trailing beat finish
  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic set_geometry(input logic [4:0] h0, input logic [7:0] s0, input logic [31:0] o0,
                              input logic [4:0] h1, input logic [7:0] s1, input logic [31:0] o1);
    write_reg(CFG_HEADS0, 32'(h0));
    write_reg(CFG_SPT0, 32'(s0));
    write_reg(CFG_OFS0, o0);
    write_reg(CFG_HEADS1, 32'(h1));
    write_reg(CFG_SPT1, 32'(s1));
    write_reg(CFG_OFS1, o1);
    cfg_valid_i <= 1'b0;
    geo_heads = '{h0, h1};
    geo_spt   = '{s0, s1};
    geo_ofs   = '{o0, o1};
  endtask

  function automatic ata_item_t rand_item(logic cmd, logic [7:0] op);
    ata_item_t it;
    it.cmd = cmd;
    it.op  = op;
    it.cnt = 8'($urandom);
    it.sec = 8'($urandom);
    it.cyl = 16'($urandom);
    it.dh  = 8'($urandom);
    return it;
  endfunction

  // One random sequence: mostly a data command followed by its buffer beats
  task automatic random_sequence();
    ata_item_t it;
    int        sel;
    int        r2;
    int        beats;
    logic [7:0] ops [4];
    ops = '{OP_READ, OP_READ_MULT, OP_WRITE, OP_WRITE_MULT};
    sel = $urandom_range(99);
    if (sel < 60) begin
      it = rand_item(1'b0, ops[$urandom_range(3)]);
      r2 = $urandom_range(99);
      it.cnt = (r2 < 3) ? 8'd0 : (r2 < 12) ? 8'($urandom) : 8'($urandom_range(1, 8));
      if ($urandom_range(9) != 0) it.sec = 8'($urandom_range(1, geo_spt[it.dh[4]]));
      send_item(it);
      if ($urandom_range(9) < 8) begin
        while (drv_mode != MODE_IDLE) send_item(rand_item(1'b1, 8'($urandom)));
      end else begin
        beats = $urandom_range(3);
        repeat (beats) send_item(rand_item(1'b1, 8'($urandom)));
      end
    end else if (sel < 70) begin
      it = rand_item(1'b0, OP_SET_MULT);
      if ($urandom_range(9) != 0) it.cnt = 8'($urandom_range(0, 8));
      send_item(it);
    end else if (sel < 90) begin
      r2 = $urandom_range(3);
      it = rand_item(1'b0, 8'($urandom));
      if (r2 == 1) it.op = OP_RECAL_HI | (8'($urandom) & OP_LO_MASK);
      if (r2 == 2) it.op = ($urandom_range(1) != 0) ? OP_IDENTIFY : OP_INIT_PARM;
      send_item(it);
    end else begin
      send_item(rand_item(1'b1, 8'($urandom)));
    end
  endtask

  // Directed rows; typed expectations only where the answer is obvious
  localparam tf_row_t DIRECTED [24] = '{
    '{'{1'b1, 8'h00, 8'h00, 8'h00, 16'h0000, 8'h00}, 1'b0, '0},
    '{'{1'b0, 8'h1F, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF}, 1'b1,
      '{1'b1, 8'h00, 8'h00, 8'h01, 16'h0000, 8'hF0, 5'h0C, 2'd0, 32'd0, 8'd0}},
    '{'{1'b0, 8'h10, 8'h00, 8'h00, 16'h0000, 8'h0F}, 1'b1,
      '{1'b1, 8'h00, 8'h00, 8'h01, 16'h0000, 8'h00, 5'h0C, 2'd0, 32'd0, 8'd0}},
    '{'{1'b0, 8'hEC, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF}, 1'b1,
      '{1'b1, 8'h00, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF, 5'h0C, 2'd0, 32'd0, 8'd0}},
    '{'{1'b0, 8'h91, 8'h00, 8'h00, 16'h0000, 8'h00}, 1'b1,
      '{1'b1, 8'h00, 8'h00, 8'h00, 16'h0000, 8'h00, 5'h0C, 2'd0, 32'd0, 8'd0}},
    '{'{1'b0, 8'hFF, 8'hAA, 8'h55, 16'hA5A5, 8'h5A}, 1'b1,
      '{1'b1, 8'h04, 8'hAA, 8'h55, 16'hA5A5, 8'h5A, 5'h1C, 2'd0, 32'd0, 8'd0}},
    '{'{1'b0, 8'h00, 8'h55, 8'hAA, 16'h5A5A, 8'hA5}, 1'b1,
      '{1'b1, 8'h04, 8'h55, 8'hAA, 16'h5A5A, 8'hA5, 5'h1C, 2'd0, 32'd0, 8'd0}},
    '{'{1'b0, 8'hC6, 8'h00, 8'h00, 16'h0000, 8'h00}, 1'b1,
      '{1'b0, 8'h00, 8'h00, 8'h00, 16'h0000, 8'h00, 5'h0C, 2'd0, 32'd0, 8'd0}},
    // read two sectors from the track end: sector, head and cylinder all wrap
    '{'{1'b0, 8'h20, 8'h02, 8'd63, 16'h0000, 8'h0F}, 1'b1,
      '{1'b0, 8'h00, 8'h00, 8'h00, 16'h0000, 8'h00, 5'h01, 2'd0, 32'd0, 8'd0}},
    '{'{1'b1, 8'h00, 8'h00, 8'h00, 16'h0000, 8'h00}, 1'b0, '0},
    '{'{1'b1, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF}, 1'b0, '0},
    '{'{1'b1, 8'h00, 8'h00, 8'h00, 16'h0000, 8'h00}, 1'b0, '0},
    // read multiple with block size zero moves one sector per beat
    '{'{1'b0, 8'hC4, 8'h03, 8'h01, 16'h0001, 8'h00}, 1'b0, '0},
    '{'{1'b1, 8'h00, 8'h00, 8'h00, 16'h0000, 8'h00}, 1'b0, '0},
    // new command while a transfer runs; count zero means 256 sectors
    '{'{1'b0, 8'h30, 8'h00, 8'h01, 16'hFFFF, 8'h1F}, 1'b1,
      '{1'b0, 8'h00, 8'h00, 8'h00, 16'h0000, 8'h00, 5'h02, 2'd0, 32'd0, 8'd0}},
    '{'{1'b1, 8'h00, 8'h00, 8'h00, 16'h0000, 8'h00}, 1'b0, '0},
    '{'{1'b1, 8'h00, 8'h00, 8'h00, 16'h0000, 8'h00}, 1'b0, '0},
    // block of four set on unit 1; the write multiple goes to unit 0, one sector per beat
    '{'{1'b0, 8'hC6, 8'h04, 8'h00, 16'h0000, 8'h10}, 1'b0, '0},
    '{'{1'b0, 8'hC5, 8'h06, 8'd62, 16'h0002, 8'hE3}, 1'b0, '0},
    '{'{1'b1, 8'h00, 8'h00, 8'h00, 16'h0000, 8'h00}, 1'b0, '0},
    '{'{1'b1, 8'h00, 8'h00, 8'h00, 16'h0000, 8'h00}, 1'b0, '0},
    '{'{1'b1, 8'h00, 8'h00, 8'h00, 16'h0000, 8'h00}, 1'b0, '0},
    '{'{1'b0, 8'hC4, 8'h01, 8'd1, 16'h0000, 8'h00}, 1'b0, '0},
    '{'{1'b1, 8'h00, 8'h00, 8'h00, 16'h0000, 8'h00}, 1'b0, '0}
  };

  // Result side: ready pattern per phase, plus one long hold-off on request
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_taken) begin
      out_ready_i <= 1'b0;
      hold_left <= 400;
      hold_taken <= 1'b1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= rcv_stall);
      if (!hold_req) hold_taken <= 1'b0;
    end
  end

  // Compare each result beat with the oldest expectation
  always @(posedge clk_i) begin
    tf_result_t got;
    tf_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{taskfile_valid_o, error_code_o, count_out_o, sector_out_o, cylinder_out_o,
              drive_head_out_o, status_bits_o, transfer_kind_o, transfer_lba_o,
              transfer_sectors_o};
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result beat %h", $time, got);
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (got.tfv !== want.tfv)
          $display("%0t: taskfile_valid exp %h got %h", $time, want.tfv, got.tfv);
        if (got.err !== want.err)
          $display("%0t: error_code exp %h got %h", $time, want.err, got.err);
        if (got.cnt !== want.cnt)
          $display("%0t: count_out exp %h got %h", $time, want.cnt, got.cnt);
        if (got.sec !== want.sec)
          $display("%0t: sector_out exp %h got %h", $time, want.sec, got.sec);
        if (got.cyl !== want.cyl)
          $display("%0t: cylinder_out exp %h got %h", $time, want.cyl, got.cyl);
        if (got.dh !== want.dh)
          $display("%0t: drive_head_out exp %h got %h", $time, want.dh, got.dh);
        if (got.st !== want.st)
          $display("%0t: status_bits exp %h got %h", $time, want.st, got.st);
        if (got.kind !== want.kind)
          $display("%0t: transfer_kind exp %h got %h", $time, want.kind, got.kind);
        if (got.lba !== want.lba)
          $display("%0t: transfer_lba exp %h got %h", $time, want.lba, got.lba);
        if (got.n !== want.n)
          $display("%0t: transfer_sectors exp %h got %h", $time, want.n, got.n);
        if (got !== want) errors++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("ata_taskfile_chs_sequencer_tb: FAIL");
      $finish;
    end
  end

  initial begin
    int target;
    int phase_snd [4];
    int phase_rcv [4];
    bit paused;
    phase_snd = '{0, 52, 0, 12};
    phase_rcv = '{0, 0, 52, 12};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at reset geometry
    foreach (DIRECTED[i]) send_beat(DIRECTED[i].item, DIRECTED[i].typed, DIRECTED[i].res);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: set_geometry(5'd1, 8'd1, 32'hFFFF_FFFF, 5'd16, 8'd255, 32'd0);
        1: set_geometry(5'd16, 8'd255, 32'hFFFF_FF00, 5'd1, 8'd1, 32'hFFFF_FFFF);
        2: set_geometry(5'($urandom_range(1, 16)), 8'($urandom_range(1, 255)), $urandom,
                        5'($urandom_range(1, 16)), 8'($urandom_range(1, 255)), $urandom);
        default: set_geometry(5'd16, 8'd63, 32'd0, 5'd16, 8'd63, 32'd0);
      endcase
      snd_idle  = phase_snd[ph];
      rcv_stall = phase_rcv[ph];
      target = results_sent + 480;
      paused = 1'b0;
      while (results_sent < target) begin
        // a sequence may add several results, so test a window, not one count
        if (ph == 0 && results_sent >= target - 400 && results_sent < target - 300)
          hold_req <= 1'b1;
        if (ph == 0 && results_sent >= target - 300) hold_req <= 1'b0;
        if (ph == 1 && !paused && results_sent >= target - 240) begin
          drain();
          paused = 1'b1;
        end
        random_sequence();
      end
      hold_req <= 1'b0;
      drain();
    end

    if (errors == 0) begin
      $display("ata_taskfile_chs_sequencer_tb: PASS");
    end else begin
      $display("ata_taskfile_chs_sequencer_tb: FAIL");
    end
    $finish;
  end

  // Leftover expectations at the end count as failures
  always @(posedge clk_i) begin
    if (cycles == CYCLE_LIMIT && expected_q.size() != 0) errors <= errors + 1;
  end

endmodule
